### sv/esd_pkg.sv
// Shared types, character codes and helpers for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] bytes_left;
    } esd_in_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       end_of_string;
    } esd_out_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_ZERO_A = 3'd2,
        MODE_ZERO_B = 3'd3,
        MODE_HEX_HI = 3'd4,
        MODE_HEX_LO = 3'd5
    } esd_mode_t;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_NUL       = 8'h00;

    // A \u escape needs the 'u' plus four more bytes after it.
    localparam logic [15:0] U_MIN_LEFT = 16'd5;
    localparam logic [15:0] LAST_LEFT  = 16'd1;

    // Value of one hex digit; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end
            return d[3:0];
        end
    endfunction

endpackage

### sv/esd_core.sv
// Input register and escape decoding state machine.
`timescale 1ns / 1ps

module esd_core
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  esd_in_t  s_data,
    output logic     res_valid,
    input  logic     res_ready,
    output esd_out_t res_data
);

    logic      in_valid_reg;
    esd_in_t   in_reg;
    esd_mode_t mode_reg;
    esd_mode_t mode_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic      fire;
    logic      last;
    logic      have;
    logic [7:0] byte_val;

    assign fire      = in_valid_reg && res_ready;
    assign s_ready   = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;
    assign last      = (in_reg.bytes_left == LAST_LEFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            nibble_reg <= 4'd0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
        end
    end

    always_comb begin
        mode_next   = MODE_NORMAL;
        nibble_next = nibble_reg;
        have        = 1'b0;
        byte_val    = 8'd0;
        case (mode_reg)
            MODE_ESCAPE: begin
                have = 1'b1;
                case (in_reg.data_byte)
                    CHAR_N:    byte_val = BYTE_LF;
                    CHAR_T:    byte_val = BYTE_TAB;
                    CHAR_R:    byte_val = BYTE_CR;
                    CHAR_ZERO: byte_val = BYTE_NUL;
                    CHAR_U: begin
                        if (in_reg.bytes_left >= U_MIN_LEFT) begin
                            have      = 1'b0;
                            mode_next = MODE_ZERO_A;
                        end else begin
                            byte_val = in_reg.data_byte;
                        end
                    end
                    default:   byte_val = in_reg.data_byte;
                endcase
            end
            MODE_ZERO_A: mode_next = MODE_ZERO_B;
            MODE_ZERO_B: mode_next = MODE_HEX_HI;
            MODE_HEX_HI: begin
                nibble_next = hex_value(in_reg.data_byte);
                mode_next   = MODE_HEX_LO;
            end
            MODE_HEX_LO: begin
                have     = 1'b1;
                byte_val = {nibble_reg, hex_value(in_reg.data_byte)};
            end
            default: begin
                if (in_reg.data_byte == CHAR_BACKSLASH) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    have     = 1'b1;
                    byte_val = in_reg.data_byte;
                end
            end
        endcase
        // The end of a string always drops any escape in progress.
        if (last) begin
            mode_next   = MODE_NORMAL;
            nibble_next = 4'd0;
        end
        res_data.has_byte      = have;
        res_data.out_byte      = have ? byte_val : 8'd0;
        res_data.end_of_string = last;
    end

    a_end_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last |=> mode_reg == MODE_NORMAL && nibble_reg == 4'd0)
        else $error("decoder state not cleared after end of string");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(mode_reg) && $stable(nibble_reg))
        else $error("decoder state changed without a transaction");

    a_zero_skip_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !last && mode_reg == MODE_ZERO_A |=> mode_reg == MODE_ZERO_B)
        else $error("first zero of a \\u escape not skipped");

    a_no_byte_while_skipping: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (mode_reg == MODE_ZERO_A || mode_reg == MODE_ZERO_B ||
        mode_reg == MODE_HEX_HI) |-> !res_data.has_byte)
        else $error("byte emitted inside a \\u escape");

endmodule

### sv/esd_out_reg.sv
// Result register between the decoder and the result channel.
`timescale 1ns / 1ps

module esd_out_reg
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     res_valid,
    output logic     res_ready,
    input  esd_out_t res_data,
    output logic     m_valid,
    input  logic     m_ready,
    output esd_out_t m_data
);

    logic     m_valid_reg;
    esd_out_t m_data_reg;

    // The register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    a_empty_byte_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.has_byte |-> m_data_reg.out_byte == 8'd0)
        else $error("result without a byte carries a nonzero value");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid_reg && m_data_reg == $past(res_data))
        else $error("result register missed a transaction");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(m_data_reg))
        else $error("result register overwritten while stalled");

endmodule

### sv/escape_sequence_decoder.sv
// Escape sequence decoder: streams a backslash-escaped string, one byte per transaction.
//
// Input channel (s_valid, s_ready, s_data): one raw byte of the string with the
// count of bytes left including it; a count of one marks the last byte.
// Result channel (m_valid, m_ready, m_data): exactly one result per input byte.
// has_byte says whether out_byte carries a decoded byte; end_of_string is set on
// the result of the last input byte. Escapes \n \t \r \0 \\ \' \" and \u00xy
// are decoded; bytes that start or continue an escape give results without a byte.
// From input transaction to result a byte passes one input register and one
// result register, with the decode logic and a small mode register between.
// Throughput is one byte per cycle while m_ready stays high; the mode register updates once per byte.
// If the receiver stalls, the result register holds its transaction and the
// input register takes one more byte only if it is empty; after that s_ready falls until
// m_ready returns.
// Synchronous reset (aresetn low) empties both registers and returns the
// decoder to plain copy mode.
`timescale 1ns / 1ps

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  esd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output esd_out_t m_data
);

    logic     res_valid;
    logic     res_ready;
    esd_out_t res_data;

    esd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    esd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for the escape sequence decoder.
`timescale 1ns / 1ps

module testbench;
    import esd_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 100;
    localparam int SCRIPT_ROWS  = 27;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;

    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] left;
        logic        typed;
        esd_out_t    want;
    } script_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    esd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    esd_out_t m_data;

    // Decoder state as the bench tracks it.
    esd_mode_t   dec_mode;
    logic [3:0]  hi_nib;

    esd_out_t    pending[$];
    logic [7:0]  text[$];
    script_row_t script [SCRIPT_ROWS];

    int  sent;
    int  mismatches;
    bit  quiet;
    int  gap_pct;
    int  stall_pct;

    escape_sequence_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #4 aclk = ~aclk;
        end
    end

    function automatic logic [3:0] digit_weight(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return c[3:0];
        end
        // Both letter cases share the low five bits, so 'A'..'F' map like 'a'..'f'.
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic decode_step(input esd_in_t item, output esd_out_t res);
        esd_mode_t  nxt;
        logic [7:0] b;
        logic       have;
        logic       last;
        begin
            nxt  = MODE_NORMAL;
            b    = 8'd0;
            have = 1'b0;
            // Only a count of exactly one marks the last byte, so no clamp is needed.
            last = (item.bytes_left == LAST_LEFT);
            case (dec_mode)
                MODE_ESCAPE: begin
                    have = 1'b1;
                    case (item.data_byte)
                        CHAR_N:    b = BYTE_LF;
                        CHAR_T:    b = BYTE_TAB;
                        CHAR_R:    b = BYTE_CR;
                        CHAR_ZERO: b = BYTE_NUL;
                        CHAR_U: begin
                            if (item.bytes_left >= U_MIN_LEFT) begin
                                have = 1'b0;
                                nxt  = MODE_ZERO_A;
                            end else begin
                                b = item.data_byte;
                            end
                        end
                        default:   b = item.data_byte;
                    endcase
                end
                MODE_ZERO_A: nxt = MODE_ZERO_B;
                MODE_ZERO_B: nxt = MODE_HEX_HI;
                MODE_HEX_HI: begin
                    hi_nib = digit_weight(item.data_byte);
                    nxt    = MODE_HEX_LO;
                end
                MODE_HEX_LO: begin
                    have = 1'b1;
                    b    = {hi_nib, digit_weight(item.data_byte)};
                end
                default: begin
                    if (item.data_byte == CHAR_BACKSLASH) begin
                        nxt = MODE_ESCAPE;
                    end else begin
                        have = 1'b1;
                        b    = item.data_byte;
                    end
                end
            endcase
            if (last) begin
                nxt    = MODE_NORMAL;
                hi_nib = 4'd0;
            end
            dec_mode          = nxt;
            res.has_byte      = have;
            res.out_byte      = have ? b : 8'd0;
            res.end_of_string = last;
        end
    endtask

    task automatic push_byte(input logic [7:0] ch, input logic [15:0] left,
                             input logic typed, input esd_out_t want);
        esd_in_t  item;
        esd_out_t predicted;
        begin
            item.data_byte  = ch;
            item.bytes_left = left;
            if (!quiet && $urandom_range(0, 99) < gap_pct) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= item;
            do @(posedge aclk); while (!s_ready);
            decode_step(item, predicted);
            pending.push_back(typed ? want : predicted);
            sent++;
        end
    endtask

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(0, 3))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h61 + 8'($urandom_range(0, 5));
            2:       return 8'h41 + 8'($urandom_range(0, 5));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fills the text queue with a random escaped string of roughly the given length.
    task automatic build_text(input int target);
        logic [7:0] pick;
        begin
            text.delete();
            while (text.size() < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: text.push_back(8'($urandom_range(0, 255)));
                    4, 5, 6: begin
                        case ($urandom_range(0, 7))
                            0:       pick = CHAR_N;
                            1:       pick = CHAR_T;
                            2:       pick = CHAR_R;
                            3:       pick = CHAR_ZERO;
                            4:       pick = CHAR_BACKSLASH;
                            5:       pick = CHAR_SQUOTE;
                            6:       pick = CHAR_DQUOTE;
                            default: pick = 8'($urandom_range(0, 255));
                        endcase
                        text.push_back(CHAR_BACKSLASH);
                        text.push_back(pick);
                    end
                    7, 8: begin
                        text.push_back(CHAR_BACKSLASH);
                        text.push_back(CHAR_U);
                        repeat (2) begin
                            text.push_back(($urandom_range(0, 3) == 0) ?
                                           8'($urandom_range(0, 255)) : CHAR_ZERO);
                        end
                        text.push_back(pick_hex());
                        text.push_back(pick_hex());
                    end
                    default: text.push_back(CHAR_BACKSLASH);
                endcase
            end
        end
    endtask

    initial begin
        script = '{
            '{8'h41,          16'd3,     1'b1, '{1'b1, 8'h41,    1'b0}},
            '{8'hFF,          16'd65535, 1'b1, '{1'b1, 8'hFF,    1'b0}},
            // A count of zero is not the end of the string.
            '{8'h00,          16'd0,     1'b1, '{1'b1, 8'h00,    1'b0}},
            '{CHAR_BACKSLASH, 16'd2,     1'b1, '{1'b0, 8'h00,    1'b0}},
            '{CHAR_N,         16'd1,     1'b1, '{1'b1, BYTE_LF,  1'b1}},
            '{CHAR_BACKSLASH, 16'd40,    1'b1, '{1'b0, 8'h00,    1'b0}},
            '{CHAR_T,         16'd39,    1'b1, '{1'b1, BYTE_TAB, 1'b0}},
            '{CHAR_BACKSLASH, 16'd38,    1'b0, '0},
            '{CHAR_R,         16'd37,    1'b1, '{1'b1, BYTE_CR,  1'b0}},
            '{CHAR_BACKSLASH, 16'd36,    1'b0, '0},
            '{CHAR_ZERO,      16'd35,    1'b1, '{1'b1, BYTE_NUL, 1'b0}},
            '{CHAR_BACKSLASH, 16'd34,    1'b0, '0},
            '{CHAR_BACKSLASH, 16'd33,    1'b1, '{1'b1, 8'h5C,    1'b0}},
            '{CHAR_BACKSLASH, 16'd32,    1'b0, '0},
            '{CHAR_SQUOTE,    16'd31,    1'b0, '0},
            '{CHAR_BACKSLASH, 16'd30,    1'b0, '0},
            '{CHAR_DQUOTE,    16'd29,    1'b0, '0},
            '{CHAR_BACKSLASH, 16'd28,    1'b0, '0},
            '{CHAR_U,         16'd27,    1'b1, '{1'b0, 8'h00,    1'b0}},
            '{CHAR_ZERO,      16'd26,    1'b0, '0},
            '{CHAR_ZERO,      16'd25,    1'b0, '0},
            '{8'h46,          16'd24,    1'b0, '0},
            '{8'h66,          16'd23,    1'b1, '{1'b1, 8'hFF,    1'b0}},
            // With only four bytes left at the 'u' it is copied as a plain byte.
            '{CHAR_BACKSLASH, 16'd5,     1'b0, '0},
            '{CHAR_U,         16'd4,     1'b1, '{1'b1, CHAR_U,   1'b0}},
            // A backslash on the last byte is dropped.
            '{CHAR_BACKSLASH, 16'd1,     1'b1, '{1'b0, 8'h00,    1'b1}},
            '{CHAR_BACKSLASH, 16'd9,     1'b0, '0}
        };
    end

    initial begin
        int         target;
        int         offset;
        int         quiet_at;
        esd_in_t    idle_item;
        begin
            idle_item  = '0;
            aresetn   <= 1'b0;
            s_valid   <= 1'b0;
            s_data    <= idle_item;
            dec_mode   = MODE_NORMAL;
            hi_nib     = 4'd0;
            sent       = 0;
            mismatches = 0;
            quiet      = 1'b0;
            gap_pct    = 20;
            stall_pct  = 20;
            repeat (12) @(posedge aclk);
            aresetn <= 1'b1;
            @(posedge aclk);

            for (int i = 0; i < SCRIPT_ROWS; i++) begin
                push_byte(script[i].ch, script[i].left, script[i].typed, script[i].want);
            end
            // The last directed row leaves the decoder inside an escape; end it here
            // so that the ending inside a skipped zero is covered as well.
            push_byte(CHAR_U, 16'd8, 1'b0, '0);
            push_byte(CHAR_ZERO, 16'd1, 1'b1, '{1'b0, 8'h00, 1'b1});

            quiet_at = sent + RANDOM_ITEMS - QUIET_TAIL;
            target   = sent + RANDOM_ITEMS;
            while (sent < target) begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
                if (sent >= quiet_at) begin
                    quiet = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // Stray bytes with arbitrary counts.
                    repeat ($urandom_range(1, 4)) begin
                        push_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                  1'b0, '0);
                    end
                end else begin
                    build_text(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12));
                    // Now and then the count never reaches one, so the string is cut off.
                    offset = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
                    for (int i = 0; i < text.size(); i++) begin
                        push_byte(text[i], 16'(text.size() - i + offset), 1'b0, '0);
                    end
                end
            end
            s_valid <= 1'b0;

            while (pending.size() != 0) @(posedge aclk);
            repeat (10) @(posedge aclk);
            if (mismatches == 0 && pending.size() == 0) begin
                $display("testbench: PASS");
            end else begin
                $display("testbench: FAIL");
            end
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 99) < stall_pct / 4) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        esd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected transaction: has_byte=%0b out_byte=%02h end=%0b",
                             m_data.has_byte, m_data.out_byte, m_data.end_of_string);
                end
            end else begin
                want = pending.pop_front();
                if (m_data.has_byte != want.has_byte || m_data.out_byte != want.out_byte
                        || m_data.end_of_string != want.end_of_string) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: expected has_byte=%0b out_byte=%02h end=%0b, %s",
                                 want.has_byte, want.out_byte, want.end_of_string,
                                 $sformatf("got has_byte=%0b out_byte=%02h end=%0b",
                                           m_data.has_byte, m_data.out_byte,
                                           m_data.end_of_string));
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
